// ===== sv/fpa_pkg.sv =====
package fpa_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned WORD_BITS_DEF = 32;

  typedef enum logic [3:0] {
    KIND_ADD      = 4'd0,
    KIND_SUB      = 4'd1,
    KIND_MUL      = 4'd2,
    KIND_DIV      = 4'd3,
    KIND_GT       = 4'd4,
    KIND_LT       = 4'd5,
    KIND_GE       = 4'd6,
    KIND_LE       = 4'd7,
    KIND_EQ       = 4'd8,
    KIND_NE       = 4'd9,
    KIND_MIN      = 4'd10,
    KIND_MAX      = 4'd11,
    KIND_INC      = 4'd12,
    KIND_DEC      = 4'd13,
    KIND_TO_INT   = 4'd14,
    KIND_FROM_INT = 4'd15
  } kind_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    kind_e      kind;
    logic       neg;
    logic       cmp;
    logic [1:0] st;
  } ctl_t;

endpackage

// ===== sv/fpa_front.sv =====
module fpa_front import fpa_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              v_i,
  input  logic [3:0]                        kind_i,
  input  logic signed [WORD_BITS-1:0]       a_i,
  input  logic signed [WORD_BITS-1:0]       b_i,
  output logic                              v_o,
  output ctl_t                              ctl_o,
  output logic [WORD_BITS-1:0]              res_o,
  output logic [WORD_BITS-1:0]              mb_o,
  output logic [WORD_BITS+FRAC_BITS-1:0]    numq_o
);

  localparam int unsigned W = WORD_BITS;
  localparam int unsigned Q = WORD_BITS + FRAC_BITS;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic              v_q;
  ctl_t              ctl_d, ctl_q;
  logic [W-1:0]      res_d, res_q, mb_d, mb_q, ma;
  logic [Q-1:0]      numq_d, numq_q;
  logic signed [W:0] ax1, bx1, s;
  logic signed [Q-1:0] ax, fw;
  logic [FRAC_BITS:0]  hi;
  logic              gt, eq;

  always_comb begin
    ma     = a_i[W-1] ? W'(-a_i) : W'(a_i);
    mb_d   = b_i[W-1] ? W'(-b_i) : W'(b_i);
    numq_d = Q'(ma) << FRAC_BITS;
    ax1    = {a_i[W-1], a_i};
    bx1    = {b_i[W-1], b_i};
    ax     = Q'(a_i);
    fw     = ax <<< FRAC_BITS;
    hi     = fw[Q-1:W-1];
    gt     = a_i > b_i;
    eq     = a_i == b_i;
    s      = ax1 + bx1;
    res_d  = '0;
    ctl_d.kind = kind_e'(kind_i);
    ctl_d.neg  = a_i[W-1] ^ b_i[W-1];
    ctl_d.cmp  = 1'b0;
    ctl_d.st   = ST_OK;
    unique case (kind_e'(kind_i))
      KIND_ADD, KIND_SUB, KIND_INC, KIND_DEC: begin
        case (kind_e'(kind_i))
          KIND_SUB: s = ax1 - bx1;
          KIND_INC: s = ax1 + (W+1)'(1);
          KIND_DEC: s = ax1 - (W+1)'(1);
          default:  s = ax1 + bx1;
        endcase
        if (s[W] != s[W-1]) begin
          res_d    = s[W] ? WMIN : WMAX;
          ctl_d.st = ST_OVF;
        end else begin
          res_d = s[W-1:0];
        end
      end
      KIND_GT:     ctl_d.cmp = gt;
      KIND_LT:     ctl_d.cmp = !gt && !eq;
      KIND_GE:     ctl_d.cmp = gt || eq;
      KIND_LE:     ctl_d.cmp = !gt;
      KIND_EQ:     ctl_d.cmp = eq;
      KIND_NE:     ctl_d.cmp = !eq;
      KIND_MIN:    res_d = gt ? b_i : a_i;
      KIND_MAX:    res_d = gt ? a_i : b_i;
      KIND_TO_INT: res_d = W'(a_i >>> FRAC_BITS);
      KIND_FROM_INT: begin
        if (hi == '0 || hi == '1) begin
          res_d = fw[W-1:0];
        end else begin
          res_d    = a_i[W-1] ? WMIN : WMAX;
          ctl_d.st = ST_OVF;
        end
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q  <= ctl_d;
      res_q  <= res_d;
      mb_q   <= mb_d;
      numq_q <= numq_d;
    end
  end

  assign v_o    = v_q;
  assign ctl_o  = ctl_q;
  assign res_o  = res_q;
  assign mb_o   = mb_q;
  assign numq_o = numq_q;

endmodule

// ===== sv/fpa_mul.sv =====
module fpa_mul import fpa_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              v_i,
  input  ctl_t                              ctl_i,
  input  logic [WORD_BITS-1:0]              res_i,
  input  logic [WORD_BITS-1:0]              mb_i,
  input  logic [WORD_BITS+FRAC_BITS-1:0]    numq_i,
  output logic                              v_o,
  output ctl_t                              ctl_o,
  output logic [WORD_BITS-1:0]              res_o,
  output logic [WORD_BITS-1:0]              mb_o,
  output logic [WORD_BITS+FRAC_BITS-1:0]    numq_o
);

  localparam int unsigned W = WORD_BITS;
  localparam int unsigned Q = WORD_BITS + FRAC_BITS;
  localparam int unsigned PW = 2 * WORD_BITS + 1;
  localparam logic [PW-1:0] HALF   = (PW'(1) << FRAC_BITS) >> 1;
  localparam logic [PW-1:0] POSLIM = PW'(1) << (W - 1);
  localparam logic [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};

  // stage one: product
  logic [1:0]       v_q;
  ctl_t             ctl1_q, ctl2_q, ctl2_d;
  logic [W-1:0]     res1_q, res2_q, res2_d, mb1_q, mb2_q;
  logic [Q-1:0]     numq1_q, numq2_q;
  logic [2*W-1:0]   prod_q;
  logic [PW-1:0]    q;
  logic [W-1:0]     ql;

  // stage two: round and saturate
  always_comb begin
    q      = (PW'(prod_q) + HALF) >> FRAC_BITS;
    ql     = q[W-1:0];
    ctl2_d = ctl1_q;
    res2_d = res1_q;
    if (ctl1_q.kind == KIND_MUL) begin
      if (!ctl1_q.neg && q >= POSLIM) begin
        res2_d    = WMAX;
        ctl2_d.st = ST_OVF;
      end else if (ctl1_q.neg && q > POSLIM) begin
        res2_d    = WMIN;
        ctl2_d.st = ST_OVF;
      end else begin
        res2_d = ctl1_q.neg ? -ql : ql;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl1_q  <= ctl_i;
      res1_q  <= res_i;
      mb1_q   <= mb_i;
      numq1_q <= numq_i;
      prod_q  <= numq_i[Q-1:FRAC_BITS] * mb_i;
      ctl2_q  <= ctl2_d;
      res2_q  <= res2_d;
      mb2_q   <= mb1_q;
      numq2_q <= numq1_q;
    end
  end

  assign v_o    = v_q[1];
  assign ctl_o  = ctl2_q;
  assign res_o  = res2_q;
  assign mb_o   = mb2_q;
  assign numq_o = numq2_q;

endmodule

// ===== sv/fpa_div_stage.sv =====
module fpa_div_stage import fpa_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              v_i,
  input  ctl_t                              ctl_i,
  input  logic [WORD_BITS-1:0]              res_i,
  input  logic [WORD_BITS-1:0]              mb_i,
  input  logic [WORD_BITS-1:0]              rem_i,
  input  logic [WORD_BITS+FRAC_BITS-1:0]    numq_i,
  output logic                              v_o,
  output ctl_t                              ctl_o,
  output logic [WORD_BITS-1:0]              res_o,
  output logic [WORD_BITS-1:0]              mb_o,
  output logic [WORD_BITS-1:0]              rem_o,
  output logic [WORD_BITS+FRAC_BITS-1:0]    numq_o
);

  localparam int unsigned W = WORD_BITS;
  localparam int unsigned Q = WORD_BITS + FRAC_BITS;

  logic         v_q, ge;
  ctl_t         ctl_q;
  logic [W-1:0] res_q, mb_q, rem_q, rem_d;
  logic [W:0]   t, diff;
  logic [Q-1:0] numq_q;

  // one quotient bit: numerator bits shift out on top, quotient bits in below
  always_comb begin
    t     = {rem_i, numq_i[Q-1]};
    diff  = t - {1'b0, mb_i};
    ge    = t >= {1'b0, mb_i};
    rem_d = ge ? diff[W-1:0] : t[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q  <= ctl_i;
      res_q  <= res_i;
      mb_q   <= mb_i;
      rem_q  <= rem_d;
      numq_q <= {numq_i[Q-2:0], ge};
    end
  end

  assign v_o    = v_q;
  assign ctl_o  = ctl_q;
  assign res_o  = res_q;
  assign mb_o   = mb_q;
  assign rem_o  = rem_q;
  assign numq_o = numq_q;

endmodule

// ===== sv/fpa_back.sv =====
module fpa_back import fpa_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              v_i,
  input  ctl_t                              ctl_i,
  input  logic [WORD_BITS-1:0]              res_i,
  input  logic [WORD_BITS-1:0]              mb_i,
  input  logic [WORD_BITS-1:0]              rem_i,
  input  logic [WORD_BITS+FRAC_BITS-1:0]    numq_i,
  output logic                              v_o,
  output logic [WORD_BITS-1:0]              res_o,
  output logic                              cmp_o,
  output logic [1:0]                        st_o
);

  localparam int unsigned W = WORD_BITS;
  localparam int unsigned Q = WORD_BITS + FRAC_BITS;
  localparam logic [Q:0]    POSLIM = (Q+1)'(1) << (W - 1);
  localparam logic [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  WMIN = {1'b1, {(W-1){1'b0}}};

  logic         v_q, cmp_q, up;
  logic [1:0]   st_d, st_q;
  logic [W-1:0] res_d, res_q, ql;
  logic [Q:0]   qr;

  // round half up on the remainder, then flag division by zero or saturate
  always_comb begin
    up    = {rem_i, 1'b0} >= {1'b0, mb_i};
    qr    = (Q+1)'(numq_i) + (Q+1)'(up);
    ql    = qr[W-1:0];
    res_d = res_i;
    st_d  = ctl_i.st;
    if (ctl_i.kind == KIND_DIV) begin
      if (mb_i == '0) begin
        res_d = '0;
        st_d  = ST_DIVZ;
      end else if (!ctl_i.neg && qr >= POSLIM) begin
        res_d = WMAX;
        st_d  = ST_OVF;
      end else if (ctl_i.neg && qr > POSLIM) begin
        res_d = WMIN;
        st_d  = ST_OVF;
      end else begin
        res_d = ctl_i.neg ? -ql : ql;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      cmp_q <= ctl_i.cmp;
      st_q  <= st_d;
    end
  end

  assign v_o   = v_q;
  assign res_o = res_q;
  assign cmp_o = cmp_q;
  assign st_o  = st_q;

endmodule

// ===== sv/fixed_point_alu_q24_8_unit.sv =====
// channel   direction   handshake                   payload
// in        input       in_valid_i / in_ready_o     kind_i, a_raw_i, b_raw_i
// out       output      out_valid_o / out_ready_i   result_raw_o, compare_true_o, status_o
//
// one word per cycle while the output is not stalled, through front, multiplier, divider chain and back
// the divider chain computes one quotient bit per stage
// reset clears the valid bits only
// a stall at the output freezes the whole pipeline, in_ready_o follows it
module fixed_point_alu_q24_8_unit import fpa_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [3:0]                  kind_i,
  input  logic signed [WORD_BITS-1:0] a_raw_i,
  input  logic signed [WORD_BITS-1:0] b_raw_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [WORD_BITS-1:0] result_raw_o,
  output logic                        compare_true_o,
  output logic [1:0]                  status_o
);

  localparam int unsigned W = WORD_BITS;
  localparam int unsigned Q = WORD_BITS + FRAC_BITS;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  logic         en;
  logic         f_v, m_v;
  ctl_t         f_ctl, m_ctl;
  logic [W-1:0] f_res, f_mb, m_res, m_mb;
  logic [Q-1:0] f_numq, m_numq;

  logic         d_v    [Q+1];
  ctl_t         d_ctl  [Q+1];
  logic [W-1:0] d_res  [Q+1];
  logic [W-1:0] d_mb   [Q+1];
  logic [W-1:0] d_rem  [Q+1];
  logic [Q-1:0] d_numq [Q+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  fpa_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .v_i(in_valid_i),
    .kind_i, .a_i(a_raw_i), .b_i(b_raw_i),
    .v_o(f_v), .ctl_o(f_ctl), .res_o(f_res), .mb_o(f_mb), .numq_o(f_numq)
  );

  fpa_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i, .rst_ni, .en_i(en), .v_i(f_v),
    .ctl_i(f_ctl), .res_i(f_res), .mb_i(f_mb), .numq_i(f_numq),
    .v_o(m_v), .ctl_o(m_ctl), .res_o(m_res), .mb_o(m_mb), .numq_o(m_numq)
  );

  assign d_v[0]    = m_v;
  assign d_ctl[0]  = m_ctl;
  assign d_res[0]  = m_res;
  assign d_mb[0]   = m_mb;
  assign d_rem[0]  = '0;
  assign d_numq[0] = m_numq;

  for (genvar k = 0; k < Q; k++) begin : g_div
    fpa_div_stage #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_stage (
      .clk_i, .rst_ni, .en_i(en), .v_i(d_v[k]),
      .ctl_i(d_ctl[k]), .res_i(d_res[k]), .mb_i(d_mb[k]),
      .rem_i(d_rem[k]), .numq_i(d_numq[k]),
      .v_o(d_v[k+1]), .ctl_o(d_ctl[k+1]), .res_o(d_res[k+1]), .mb_o(d_mb[k+1]),
      .rem_o(d_rem[k+1]), .numq_o(d_numq[k+1])
    );
  end

  fpa_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .en_i(en), .v_i(d_v[Q]),
    .ctl_i(d_ctl[Q]), .res_i(d_res[Q]), .mb_i(d_mb[Q]),
    .rem_i(d_rem[Q]), .numq_i(d_numq[Q]),
    .v_o(out_valid_o), .res_o(result_raw_o), .cmp_o(compare_true_o), .st_o(status_o)
  );

  a_divz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DIVZ |-> result_raw_o == '0)
    else $error("division by zero word with nonzero result");

  a_cmp_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compare_true_o |-> status_o == ST_OK && result_raw_o == '0)
    else $error("compare word with result or status set");

  a_ovf_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OVF |->
      result_raw_o == WMAX || result_raw_o == WMIN)
    else $error("overflow word not at a bound");

endmodule
